// ===== hdl/sebfr_pkg.sv =====
// Shared types, constants and field layouts of the STX/ETX frame receiver.
// Used by the front end, the descriptor queue, the back end, the top level and the checker.
package sebfr_pkg;

	localparam int BUFFER_DEPTH = 32;
	localparam int PARAM_COUNT  = 11;
	localparam int QUEUE_DEPTH  = 2;

	// Fixed frame positions.
	localparam int LEN_HI_POS = 1;
	localparam int LEN_LO_POS = 2;
	localparam int CMD_POS    = 4;
	localparam int STATUS_POS = 5;
	localparam int PARAM_BASE = 5;

	localparam int BYTE_W    = 8;
	localparam int LEN_W     = 6;
	localparam int IDX_W     = 4;
	localparam int CFG_IDX_W = 3;
	localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
	localparam int ADDR_W    = $clog2(BUFFER_DEPTH);
	localparam int STEP_W    = $clog2(PARAM_COUNT + 1);
	localparam int PIDX_W    = (PARAM_COUNT > 1) ? $clog2(PARAM_COUNT) : 1;
	localparam int QPTR_W    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W    = $clog2(QUEUE_DEPTH + 1);

	localparam int OUT_FIELDS_W = BYTE_W + 1 + LEN_W + BYTE_W + IDX_W;
	localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

	localparam logic ACTION_BYTE  = 1'b0;
	localparam logic ACTION_CLEAR = 1'b1;
	localparam logic KIND_SUMMARY = 1'b0;
	localparam logic KIND_PARAM   = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_START_BYTE   = 3'd0,
		REG_END_BYTE     = 3'd1,
		REG_OK_STATUS    = 3'd2,
		REG_PARAM_CMD    = 3'd3,
		REG_PARAM_LENGTH = 3'd4
	} cfg_reg_t;

	typedef struct packed {
		logic [BYTE_W-1:0] start_byte;
		logic [BYTE_W-1:0] end_byte;
		logic [BYTE_W-1:0] ok_status;
		logic [BYTE_W-1:0] param_command;
		logic [BYTE_W-1:0] param_frame_length;
	} cfg_t;

	// Snapshot of an accepted frame, taken when its check byte is accepted.
	typedef struct packed {
		logic [BYTE_W-1:0]                  command;
		logic                               exec_ok;
		logic [LEN_W-1:0]                   frame_length;
		logic                               has_params;
		logic [PARAM_COUNT-1:0][BYTE_W-1:0] params;
	} frame_desc_t;

	typedef struct packed {
		logic              kind;
		logic [BYTE_W-1:0] command;
		logic              exec_ok;
		logic [LEN_W-1:0]  frame_length;
		logic [BYTE_W-1:0] param_value;
		logic [IDX_W-1:0]  param_index;
		logic              last;
	} result_t;

endpackage

// ===== hdl/stx_etx_bcc_frame_receiver.sv =====
// Top level of the STX/ETX frame receiver with XOR block check: configuration
// registers, stream packing, and the front end, descriptor queue and back end.
// Depends on sebfr_pkg, sebfr_front, sebfr_queue and sebfr_back.

// The receiver takes one byte beat per cycle (tuser high clears the parser) and
// hunts for the start byte, storing and XOR-checking bytes until an end byte and
// a matching check byte with the right big-endian length close the frame. Each
// accepted frame is handed as a descriptor to a two-entry queue; the back end
// then emits one summary beat, followed for a parameter report by one beat per
// parameter byte, one beat per cycle from its output register while m_tready is
// high, tlast on the final one. Input beats stall only while the queue is full,
// so the input side runs at one byte per cycle as long as result beats are
// drained at least as fast as frames complete. Configuration writes are always
// ready and are meant for when the block is idle.
module stx_etx_bcc_frame_receiver import sebfr_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [7:0]             s_tdata,   // [7:0] rx_byte
	input  logic                   s_tuser,   // [0] action
	// Result stream.
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,   // [7:0] command, [8] exec_ok,
	                                          // [14:9] frame_length, [22:15] param_value,
	                                          // [26:23] param_index, rest zero
	output logic                   m_tuser,   // [0] kind
	output logic                   m_tlast,
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [BYTE_W-1:0]      cfg_data
);

	cfg_t        cfg_q;
	logic        q_full;
	logic        q_push;
	frame_desc_t q_push_desc;
	logic        q_pop;
	frame_desc_t q_pop_desc;
	logic        q_not_empty;
	result_t     result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_byte         <= 8'h02;
			cfg_q.end_byte           <= 8'h03;
			cfg_q.ok_status          <= 8'h4F;
			cfg_q.param_command      <= 8'h0B;
			cfg_q.param_frame_length <= 8'h11;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_START_BYTE:   cfg_q.start_byte         <= cfg_data;
				REG_END_BYTE:     cfg_q.end_byte           <= cfg_data;
				REG_OK_STATUS:    cfg_q.ok_status          <= cfg_data;
				REG_PARAM_CMD:    cfg_q.param_command      <= cfg_data;
				REG_PARAM_LENGTH: cfg_q.param_frame_length <= cfg_data;
				default: ;
			endcase
		end
	end

	sebfr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_action  (s_tuser),
		.in_byte    (s_tdata),
		.queue_full (q_full),
		.push       (q_push),
		.push_desc  (q_push_desc)
	);

	sebfr_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_desc (q_push_desc),
		.full      (q_full),
		.pop       (q_pop),
		.pop_desc  (q_pop_desc),
		.not_empty (q_not_empty)
	);

	sebfr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_not_empty),
		.q_desc     (q_pop_desc),
		.pop        (q_pop),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_result (result)
	);

	assign m_tdata = {{OUT_PAD_W{1'b0}}, result.param_index, result.param_value,
	                  result.frame_length, result.exec_ok, result.command};
	assign m_tuser = result.kind;
	assign m_tlast = result.last;

endmodule

// ===== hdl/sebfr_front.sv =====
// Front end of the frame receiver: start hunting, frame store, running XOR and frame check.
// Depends on sebfr_pkg; pushes one descriptor per accepted frame into the queue.
module sebfr_front import sebfr_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              in_action,
	input  logic [BYTE_W-1:0] in_byte,
	input  logic              queue_full,
	output logic              push,
	output frame_desc_t       push_desc
);

	typedef enum logic [1:0] {
		PH_HUNT  = 2'd0,
		PH_BODY  = 2'd1,
		PH_CHECK = 2'd2
	} phase_t;

	phase_t                              phase_q;
	logic [CNT_W-1:0]                    count_q;
	logic [BYTE_W-1:0]                   xor_q;
	logic [BUFFER_DEPTH-1:0][BYTE_W-1:0] store_q;

	logic [BUFFER_DEPTH-1:0][BYTE_W-1:0] post;
	logic [2*BYTE_W-1:0]                 declared;
	logic [ADDR_W-1:0]                   wr_addr;
	logic                                accept;
	logic                                full;
	logic                                frame_ok;

	assign in_ready = !queue_full;
	assign accept   = in_valid && in_ready;
	assign full     = (count_q >= CNT_W'(BUFFER_DEPTH));
	assign wr_addr  = count_q[ADDR_W-1:0];
	assign declared = {store_q[LEN_HI_POS], store_q[LEN_LO_POS]};
	assign frame_ok = (declared == (2*BYTE_W)'(count_q)) && (xor_q == in_byte) && !full;

	// The summary fields read the store as it stands once the check byte is written.
	always_comb begin
		for (int p = 0; p < BUFFER_DEPTH; p++) begin
			post[p] = (count_q == CNT_W'(p)) ? in_byte : store_q[p];
		end
	end

	assign push = accept && (in_action == ACTION_BYTE) && (phase_q == PH_CHECK) && frame_ok;

	assign push_desc.command      = post[CMD_POS];
	assign push_desc.exec_ok      = (post[STATUS_POS] == cfg.ok_status);
	assign push_desc.frame_length = LEN_W'(count_q + CNT_W'(1));
	assign push_desc.has_params   = (post[CMD_POS] == cfg.param_command) &&
	                                (post[LEN_LO_POS] == cfg.param_frame_length);

	for (genvar i = 0; i < PARAM_COUNT; i++) begin : g_param
		if (PARAM_BASE + i < BUFFER_DEPTH) begin : g_in
			assign push_desc.params[i] = post[PARAM_BASE + i];
		end else begin : g_out
			assign push_desc.params[i] = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			count_q <= '0;
			xor_q   <= '0;
			store_q <= '0;
		end else if (accept) begin
			if (in_action == ACTION_CLEAR) begin
				phase_q <= PH_HUNT;
				count_q <= '0;
				xor_q   <= '0;
				store_q <= '0;
			end else begin
				unique case (phase_q)
					PH_BODY: begin
						if (full) begin
							phase_q <= PH_HUNT;
							count_q <= '0;
							xor_q   <= '0;
						end else begin
							store_q[wr_addr] <= in_byte;
							count_q          <= count_q + CNT_W'(1);
							xor_q            <= xor_q ^ in_byte;
							if (in_byte == cfg.end_byte) begin
								phase_q <= PH_CHECK;
							end
						end
					end
					PH_CHECK: begin
						if (full) begin
							phase_q <= PH_HUNT;
							count_q <= '0;
							xor_q   <= '0;
						end else if (frame_ok) begin
							store_q[wr_addr] <= in_byte;
							count_q          <= count_q + CNT_W'(1);
							phase_q          <= PH_HUNT;
						end else begin
							// A failed check byte is body data, and collection goes on.
							store_q[wr_addr] <= in_byte;
							count_q          <= count_q + CNT_W'(1);
							xor_q            <= xor_q ^ in_byte;
							phase_q          <= PH_BODY;
						end
					end
					default: begin
						phase_q <= PH_HUNT;
						if (in_byte == cfg.start_byte) begin
							store_q[0] <= in_byte;
							count_q    <= CNT_W'(1);
							xor_q      <= in_byte;
							phase_q    <= PH_BODY;
						end
					end
				endcase
			end
		end
	end

endmodule

// ===== hdl/sebfr_queue.sv =====
// Short queue of frame descriptors between the front end and the back end.
// Depends on sebfr_pkg for the descriptor type and the queue depth.
module sebfr_queue import sebfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  frame_desc_t push_desc,
	output logic        full,
	input  logic        pop,
	output frame_desc_t pop_desc,
	output logic        not_empty
);

	frame_desc_t       entries_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] fill_q;
	logic              do_push;
	logic              do_pop;

	assign full      = (fill_q == QCNT_W'(QUEUE_DEPTH));
	assign not_empty = (fill_q != '0);
	assign pop_desc  = entries_q[rd_ptr_q];
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;

	function automatic logic [QPTR_W-1:0] next_ptr(input logic [QPTR_W-1:0] ptr);
		next_ptr = (ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= next_ptr(wr_ptr_q);
			end
			if (do_pop) begin
				rd_ptr_q <= next_ptr(rd_ptr_q);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + QCNT_W'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ===== hdl/sebfr_back.sv =====
// Back end of the frame receiver: turns each descriptor into a summary beat and,
// for a parameter report, the parameter beats. Depends on sebfr_pkg.
module sebfr_back import sebfr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_valid,
	input  frame_desc_t q_desc,
	output logic        pop,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_result
);

	frame_desc_t       cur_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic              out_valid_q;
	result_t           out_q;

	logic              out_free;
	logic              fire;
	logic              is_final;
	logic [STEP_W-1:0] pidx;
	result_t           res;

	assign out_free = !out_valid_q || out_ready;
	assign fire     = busy_q && out_free;
	assign is_final = ((step_q == '0) && !cur_q.has_params) ||
	                  (step_q == STEP_W'(PARAM_COUNT));
	assign pop      = q_valid && (!busy_q || (fire && is_final));
	assign pidx     = step_q - STEP_W'(1);

	// Step zero is the summary; step k carries parameter byte k-1.
	always_comb begin
		res.command      = cur_q.command;
		res.exec_ok      = cur_q.exec_ok;
		res.frame_length = cur_q.frame_length;
		res.last         = is_final;
		if (step_q == '0) begin
			res.kind        = KIND_SUMMARY;
			res.param_value = '0;
			res.param_index = '0;
		end else begin
			res.kind        = KIND_PARAM;
			res.param_value = cur_q.params[pidx[PIDX_W-1:0]];
			res.param_index = IDX_W'(pidx);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			cur_q       <= '0;
			out_q       <= '0;
		end else begin
			if (out_free) begin
				out_valid_q <= fire;
			end
			if (fire) begin
				out_q <= res;
				if (is_final) begin
					busy_q <= 1'b0;
					step_q <= '0;
				end else begin
					step_q <= step_q + STEP_W'(1);
				end
			end
			if (pop) begin
				cur_q  <= q_desc;
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign out_result = out_q;

endmodule

// ===== hdl/sebfr_checker.sv =====
// Port-level checker for the STX/ETX frame receiver's result stream, bound to the top level.
// Depends on sebfr_pkg for the parameter count and the result field layout.
module sebfr_checker import sebfr_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic                   m_tuser,
	input logic                   m_tlast
);

	localparam int VAL_LSB = BYTE_W + 1 + LEN_W;
	localparam int IDX_LSB = VAL_LSB + BYTE_W;

	logic              beat;
	logic [IDX_W-1:0]  idx;
	logic [BYTE_W-1:0] val;
	logic              exp_param_q;
	logic [IDX_W-1:0]  exp_idx_q;

	assign beat = m_tvalid && m_tready;
	assign idx  = m_tdata[IDX_LSB +: IDX_W];
	assign val  = m_tdata[VAL_LSB +: BYTE_W];

	// Tracks where in a summary-plus-parameters run the next beat must fall.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_param_q <= 1'b0;
			exp_idx_q   <= '0;
		end else if (beat) begin
			if (m_tlast) begin
				exp_param_q <= 1'b0;
				exp_idx_q   <= '0;
			end else if (m_tuser == KIND_SUMMARY) begin
				exp_param_q <= 1'b1;
				exp_idx_q   <= '0;
			end else begin
				exp_param_q <= 1'b1;
				exp_idx_q   <= exp_idx_q + IDX_W'(1);
			end
		end
	end

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
		$stable(m_tlast))
		else $error("result beat changed while stalled");

	a_summary_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_SUMMARY) |-> (val == '0) && (idx == '0))
		else $error("summary beat carries parameter fields");

	a_param_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tuser == KIND_PARAM) |->
		(m_tlast == (idx == IDX_W'(PARAM_COUNT - 1))))
		else $error("tlast misplaced in parameter run");

	a_run_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && exp_param_q |-> (m_tuser == KIND_PARAM) && (idx == exp_idx_q))
		else $error("parameter beat out of order");

endmodule

bind stx_etx_bcc_frame_receiver sebfr_checker u_sebfr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
